FILE: sv/stereo_frame_fifo_with_underrun_assert.svh
// ----------------------------------------------------------------------------
// stereo frame fifo assertion macros
// shared concurrent assertion forms, clocked and reset-qualified
// ----------------------------------------------------------------------------
`ifndef STEREO_FRAME_FIFO_WITH_UNDERRUN_ASSERT_SVH
`define STEREO_FRAME_FIFO_WITH_UNDERRUN_ASSERT_SVH

// same-cycle implication
`define SFF_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sff assertion failed");

// next-cycle implication
`define SFF_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sff assertion failed");

`endif

FILE: sv/sff_pkg.sv
// ----------------------------------------------------------------------------
// sff_pkg
// types and constants of the stereo frame fifo
// ----------------------------------------------------------------------------
package sff_pkg;

  localparam int OP_W     = 3;
  localparam int BLK_W    = 17;
  localparam int SAMPLE_W = 32;
  localparam int CNT_W    = 13;
  localparam int STATUS_W = 2;
  localparam int UND_W    = 32;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE_BEGIN = 3'd0,
    OP_WRITE_FRAME = 3'd1,
    OP_READ_BEGIN  = 3'd2,
    OP_READ_FRAME  = 3'd3,
    OP_CLEAR_UND   = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_REJECT   = 2'd1,
    ST_NO_BLOCK = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic capture;  // latch the word and start the frame read
    logic execute;  // apply the op and load the result register
  } sff_cmd_t;

endpackage

FILE: sv/sff_in_if.sv
// ----------------------------------------------------------------------------
// sff_in_if
// input channel of the stereo frame fifo: valid, ready and one op word
// ----------------------------------------------------------------------------
interface sff_in_if
  import sff_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [BLK_W-1:0]    block_frames;
  logic [SAMPLE_W-1:0] left_in;
  logic [SAMPLE_W-1:0] right_in;
  logic                host_underflow;

  modport source (
    output valid, op, block_frames, left_in, right_in, host_underflow,
    input  ready
  );

  modport sink (
    input  valid, op, block_frames, left_in, right_in, host_underflow,
    output ready
  );
endinterface

FILE: sv/sff_out_if.sv
// ----------------------------------------------------------------------------
// sff_out_if
// output channel of the stereo frame fifo: valid, ready and one result word
// ----------------------------------------------------------------------------
interface sff_out_if
  import sff_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SAMPLE_W-1:0] left_out;
  logic [SAMPLE_W-1:0] right_out;
  logic [CNT_W-1:0]    granted_frames;
  logic [CNT_W-1:0]    occupancy;
  logic [UND_W-1:0]    underrun_count;

  modport source (
    output valid, status, left_out, right_out, granted_frames, occupancy,
           underrun_count,
    input  ready
  );

  modport sink (
    input  valid, status, left_out, right_out, granted_frames, occupancy,
           underrun_count,
    output ready
  );
endinterface

FILE: sv/stereo_frame_fifo_with_underrun.sv
// ----------------------------------------------------------------------------
// stereo_frame_fifo_with_underrun
// ring fifo of stereo frames with block writes, block reads and underrun count
// ----------------------------------------------------------------------------
// Each input word is one op (write_begin, write_frame, read_begin, read_frame,
// clear_underrun_count) and yields exactly one result word. A word is latched,
// which starts the registered read of the frame store, and its op is then
// applied once the result register is free; no new word is taken until then.
// The result register lets the next word be taken while a finished result
// still waits. A capacity write empties the ring and keeps the underrun count;
// the user must do it only while the block is idle, which the block itself
// does not enforce. The frame store has no reset, which is harmless since only
// committed frames are ever read back.
module stereo_frame_fifo_with_underrun
  import sff_pkg::*;
#(
  parameter int MAX_FRAMES = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_data_i,
  sff_in_if.sink           in_if,
  sff_out_if.source        out_if
);
  sff_cmd_t            cmd;
  logic [STATUS_W-1:0] status;

  sff_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .cmd_o       (cmd)
  );

  sff_dp #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .cmd_i            (cmd),
    .op_i             (in_if.op),
    .block_frames_i   (in_if.block_frames),
    .left_i           (in_if.left_in),
    .right_i          (in_if.right_in),
    .host_underflow_i (in_if.host_underflow),
    .status_o         (status),
    .left_o           (out_if.left_out),
    .right_o          (out_if.right_out),
    .granted_o        (out_if.granted_frames),
    .occupancy_o      (out_if.occupancy),
    .underrun_o       (out_if.underrun_count)
  );

  assign out_if.status = status;
endmodule

FILE: sv/sff_ram.sv
// ----------------------------------------------------------------------------
// sff_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module sff_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

FILE: sv/sff_ctrl.sv
// ----------------------------------------------------------------------------
// sff_ctrl
// sequencer of the stereo frame fifo: takes a word, executes it, hands the
// result to the output register
// ----------------------------------------------------------------------------
`include "stereo_frame_fifo_with_underrun_assert.svh"

module sff_ctrl
  import sff_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output sff_cmd_t cmd_o
);
  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  // result register can take a new word this cycle
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_EXEC: begin
        cmd_o.execute = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.execute) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `SFF_ASSERT_IMPL(a_cmd_excl, clk_i, rst_ni, cmd_o.execute, !cmd_o.capture)
  `SFF_ASSERT_IMPL(a_valid_from_exec, clk_i, rst_ni, $rose(out_valid_q), $past(cmd_o.execute))
  `SFF_ASSERT_NEXT(a_capture_then_exec, clk_i, rst_ni, cmd_o.capture, state_q == S_EXEC)
endmodule

FILE: sv/sff_dp.sv
// ----------------------------------------------------------------------------
// sff_dp
// datapath of the stereo frame fifo: ring indices, block counters, underrun
// counter, frame store and result register
// ----------------------------------------------------------------------------
`include "stereo_frame_fifo_with_underrun_assert.svh"

module sff_dp
  import sff_pkg::*;
#(
  parameter int MAX_FRAMES = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CNT_W-1:0]    cfg_data_i,
  input  sff_cmd_t            cmd_i,
  input  logic [OP_W-1:0]     op_i,
  input  logic [BLK_W-1:0]    block_frames_i,
  input  logic [SAMPLE_W-1:0] left_i,
  input  logic [SAMPLE_W-1:0] right_i,
  input  logic                host_underflow_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [SAMPLE_W-1:0] left_o,
  output logic [SAMPLE_W-1:0] right_o,
  output logic [CNT_W-1:0]    granted_o,
  output logic [CNT_W-1:0]    occupancy_o,
  output logic [UND_W-1:0]    underrun_o
);
  localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CW = $clog2(MAX_FRAMES + 1);
  localparam int LW = (CW > CNT_W) ? CW : CNT_W;
  localparam int FW = 2 * SAMPLE_W;

  // ring add with one wrap, the sum of both operands below twice the capacity
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a,
                                             input logic [CW-1:0] b,
                                             input logic [CW-1:0] c);
    logic [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    if (s >= (CW+1)'(c)) s = s - (CW+1)'(c);
    return AW'(s);
  endfunction

  // registers
  logic [CNT_W-1:0]    cap_q;
  logic [AW-1:0]       widx_q, widx_d;
  logic [AW-1:0]       ridx_q, ridx_d;
  logic [CW-1:0]       committed_q, committed_d;
  logic [CW-1:0]       pending_q, pending_d;
  logic [BLK_W-1:0]    wrem_q, wrem_d;
  logic [CW-1:0]       rd_stored_q, rd_stored_d;
  logic [BLK_W-1:0]    rd_zero_q, rd_zero_d;
  logic [UND_W-1:0]    und_q, und_d;

  // latched word
  logic [OP_W-1:0]     op_q;
  logic [BLK_W-1:0]    cnt_q;
  logic [SAMPLE_W-1:0] lin_q, rin_q;
  logic                flag_q;

  // result register
  status_e             status_q, status_d;
  logic [SAMPLE_W-1:0] lout_q, lout_d, rout_q, rout_d;
  logic [CW-1:0]       granted_q, granted_d;

  // frame store ports
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [FW-1:0]       ram_rdata;

  logic [CW-1:0]       eff_cap;
  logic [LW-1:0]       cap_ext;
  logic [BLK_W-1:0]    cap_x, comm_x, grant_x;
  logic [CW-1:0]       pend_inc;

  always_comb begin
    cap_ext = LW'(cap_q);
    if (cap_q == '0) begin
      eff_cap = CW'(1);
    end else if (cap_ext > LW'(MAX_FRAMES)) begin
      eff_cap = CW'(MAX_FRAMES);
    end else begin
      eff_cap = CW'(cap_q);
    end
  end

  assign cap_x    = BLK_W'(eff_cap);
  assign comm_x   = BLK_W'(committed_q);
  assign grant_x  = (comm_x < cnt_q) ? comm_x : cnt_q;
  assign pend_inc = pending_q + CW'(1);

  always_comb begin
    widx_d      = widx_q;
    ridx_d      = ridx_q;
    committed_d = committed_q;
    pending_d   = pending_q;
    wrem_d      = wrem_q;
    rd_stored_d = rd_stored_q;
    rd_zero_d   = rd_zero_q;
    und_d       = und_q;
    status_d    = ST_OK;
    lout_d      = '0;
    rout_d      = '0;
    granted_d   = '0;
    ram_we      = 1'b0;
    ram_waddr   = ring_add(widx_q, pending_q, eff_cap);
    unique case (op_e'(op_q))
      OP_WRITE_BEGIN: begin
        pending_d = '0;
        wrem_d    = '0;
        if (cnt_q > cap_x || cnt_q > cap_x - comm_x) begin
          status_d = ST_REJECT;
        end else begin
          wrem_d = cnt_q;
        end
      end
      OP_WRITE_FRAME: begin
        if (wrem_q == '0) begin
          status_d = ST_NO_BLOCK;
        end else begin
          ram_we    = 1'b1;
          pending_d = pend_inc;
          wrem_d    = wrem_q - BLK_W'(1);
          // last frame commits the block
          if (wrem_q == BLK_W'(1)) begin
            committed_d = committed_q + pend_inc;
            widx_d      = ring_add(widx_q, pend_inc, eff_cap);
            pending_d   = '0;
          end
        end
      end
      OP_READ_BEGIN: begin
        rd_stored_d = CW'(grant_x);
        rd_zero_d   = cnt_q - grant_x;
        granted_d   = CW'(grant_x);
        if ((grant_x < cnt_q || flag_q) && und_q != '1) begin
          und_d = und_q + UND_W'(1);
        end
      end
      OP_READ_FRAME: begin
        if (rd_stored_q != '0) begin
          lout_d      = ram_rdata[SAMPLE_W-1:0];
          rout_d      = ram_rdata[FW-1:SAMPLE_W];
          ridx_d      = ring_add(ridx_q, CW'(1), eff_cap);
          committed_d = committed_q - CW'(1);
          rd_stored_d = rd_stored_q - CW'(1);
        end else if (rd_zero_q != '0) begin
          rd_zero_d = rd_zero_q - BLK_W'(1);
        end else begin
          status_d = ST_NO_BLOCK;
        end
      end
      OP_CLEAR_UND: begin
        und_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CNT_W'(MAX_FRAMES);
      widx_q      <= '0;
      ridx_q      <= '0;
      committed_q <= '0;
      pending_q   <= '0;
      wrem_q      <= '0;
      rd_stored_q <= '0;
      rd_zero_q   <= '0;
      und_q       <= '0;
    end else if (cfg_we_i) begin
      // capacity write empties the ring, underrun count kept
      cap_q       <= cfg_data_i;
      widx_q      <= '0;
      ridx_q      <= '0;
      committed_q <= '0;
      pending_q   <= '0;
      wrem_q      <= '0;
      rd_stored_q <= '0;
      rd_zero_q   <= '0;
    end else if (cmd_i.execute) begin
      widx_q      <= widx_d;
      ridx_q      <= ridx_d;
      committed_q <= committed_d;
      pending_q   <= pending_d;
      wrem_q      <= wrem_d;
      rd_stored_q <= rd_stored_d;
      rd_zero_q   <= rd_zero_d;
      und_q       <= und_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_i;
      cnt_q  <= block_frames_i;
      lin_q  <= left_i;
      rin_q  <= right_i;
      flag_q <= host_underflow_i;
    end
    if (cmd_i.execute) begin
      status_q  <= status_d;
      lout_q    <= lout_d;
      rout_q    <= rout_d;
      granted_q <= granted_d;
    end
  end

  // frame read starts with the capture, data ready for execute
  sff_ram #(
    .WIDTH (FW),
    .DEPTH (MAX_FRAMES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.execute && ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({rin_q, lin_q}),
    .re_i    (cmd_i.capture),
    .raddr_i (ridx_q),
    .rdata_o (ram_rdata)
  );

  assign status_o    = status_q;
  assign left_o      = lout_q;
  assign right_o     = rout_q;
  assign granted_o   = CNT_W'(granted_q);
  assign occupancy_o = CNT_W'(committed_q);
  assign underrun_o  = und_q;

  `SFF_ASSERT_IMPL(a_room, clk_i, rst_ni, 1'b1, (CW+1)'(committed_q) + (CW+1)'(pending_q) <= (CW+1)'(eff_cap))
  `SFF_ASSERT_IMPL(a_grant_held, clk_i, rst_ni, 1'b1, rd_stored_q <= committed_q)
  `SFF_ASSERT_IMPL(a_widx_range, clk_i, rst_ni, 1'b1, (CW+1)'(widx_q) < (CW+1)'(eff_cap))
endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the stereo frame fifo: a driver feeds queued op
// words under random valid gaps, a monitor applies random ready stalls and
// checks every result word against a built-in model of the ring, the block
// counters and the underrun count, across several capacity settings
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sff_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 11;
  localparam int RING_DEPTH     = 4096;
  localparam int MAX_BLOCK      = 65536;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [BLK_W-1:0]    block_frames;
    logic [SAMPLE_W-1:0] left_in;
    logic [SAMPLE_W-1:0] right_in;
    logic                host_underflow;
  } fifo_word_t;

  typedef struct packed {
    fifo_word_t word;
    logic       wait_drain;
  } queued_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SAMPLE_W-1:0] left_out;
    logic [SAMPLE_W-1:0] right_out;
    logic [CNT_W-1:0]    granted;
    logic [CNT_W-1:0]    occupancy;
    logic [UND_W-1:0]    underruns;
  } fifo_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_data = '0;

  sff_in_if  in_ch ();
  sff_out_if out_ch ();

  stereo_frame_fifo_with_underrun #(
    .MAX_FRAMES (RING_DEPTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  always begin
    #(CLK_PERIOD / 2) clk_i = 1'b1;
    #(CLK_PERIOD / 2) clk_i = 1'b0;
  end

  queued_word_t pending_words[$];
  fifo_result_t due_results[$];
  int           send_idle_pct = 15;
  int           recv_idle_pct = 48;
  int           fail_count = 0;
  int           stall_cycles = 0;

  // ring model
  logic [2*SAMPLE_W-1:0] ring_mem [RING_DEPTH];
  int unsigned           cap_setting;
  int unsigned           wr_base, rd_pos, committed, staged;
  int unsigned           wr_left, rd_left, fill_left;
  logic [UND_W-1:0]      und_events;

  function automatic int unsigned ring_size();
    if (cap_setting < 1) return 1;
    if (cap_setting > RING_DEPTH) return RING_DEPTH;
    return cap_setting;
  endfunction

  function automatic int unsigned ring_wrap(int unsigned a, int unsigned b);
    int unsigned s;
    s = a + b;
    if (s >= ring_size()) s -= ring_size();
    return s;
  endfunction

  function automatic void set_capacity(logic [CNT_W-1:0] value);
    cap_setting = value;
    wr_base = 0;
    rd_pos = 0;
    committed = 0;
    staged = 0;
    wr_left = 0;
    rd_left = 0;
    fill_left = 0;
  endfunction

  function automatic fifo_result_t apply_fifo_word(fifo_word_t w);
    fifo_result_t      r;
    int unsigned       sz, grant;
    logic [2*SAMPLE_W-1:0] f;
    r = '0;
    sz = ring_size();
    case (w.op)
      OP_WRITE_BEGIN: begin
        // an unfinished block is dropped first
        staged = 0;
        wr_left = 0;
        if (w.block_frames > sz || w.block_frames > sz - committed) begin
          r.status = ST_REJECT;
        end else begin
          wr_left = w.block_frames;
        end
      end
      OP_WRITE_FRAME: begin
        if (wr_left == 0) begin
          r.status = ST_NO_BLOCK;
        end else begin
          ring_mem[ring_wrap(wr_base, staged)] = {w.right_in, w.left_in};
          staged++;
          wr_left--;
          // block becomes readable with its last frame
          if (wr_left == 0) begin
            committed += staged;
            wr_base = ring_wrap(wr_base, staged);
            staged = 0;
          end
        end
      end
      OP_READ_BEGIN: begin
        grant = (committed < w.block_frames) ? committed : w.block_frames;
        rd_left = grant;
        fill_left = w.block_frames - grant;
        r.granted = CNT_W'(grant);
        if ((grant < w.block_frames || w.host_underflow) && und_events != '1) begin
          und_events++;
        end
      end
      OP_READ_FRAME: begin
        if (rd_left != 0) begin
          f = ring_mem[rd_pos];
          r.left_out = f[SAMPLE_W-1:0];
          r.right_out = f[2*SAMPLE_W-1:SAMPLE_W];
          rd_pos = ring_wrap(rd_pos, 1);
          committed--;
          rd_left--;
        end else if (fill_left != 0) begin
          fill_left--;
        end else begin
          r.status = ST_NO_BLOCK;
        end
      end
      OP_CLEAR_UND: begin
        und_events = '0;
      end
      default: begin
      end
    endcase
    r.occupancy = CNT_W'(committed);
    r.underruns = und_events;
    return r;
  endfunction

  function automatic string show_result(fifo_result_t r);
    return $sformatf("status %0d left %h right %h granted %0d occupancy %0d underruns %0d",
                     r.status, r.left_out, r.right_out, r.granted, r.occupancy,
                     r.underruns);
  endfunction

  // driver: predicts on acceptance, then presents the next queued word
  always @(posedge clk_i or negedge rst_ni) begin
    fifo_word_t   seen;
    queued_word_t head;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        seen = '{op: in_ch.op, block_frames: in_ch.block_frames,
                 left_in: in_ch.left_in, right_in: in_ch.right_in,
                 host_underflow: in_ch.host_underflow};
        due_results.push_back(apply_fifo_word(seen));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct &&
            !(pending_words[0].wait_drain && due_results.size() != 0)) begin
          head = pending_words.pop_front();
          in_ch.valid          <= 1'b1;
          in_ch.op             <= head.word.op;
          in_ch.block_frames   <= head.word.block_frames;
          in_ch.left_in        <= head.word.left_in;
          in_ch.right_in       <= head.word.right_in;
          in_ch.host_underflow <= head.word.host_underflow;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random ready stalls, in-order compare of result words
  always @(posedge clk_i or negedge rst_ni) begin
    fifo_result_t got, want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{status: out_ch.status, left_out: out_ch.left_out,
                right_out: out_ch.right_out, granted: out_ch.granted_frames,
                occupancy: out_ch.occupancy, underruns: out_ch.underrun_count};
        if (due_results.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("%0t: unexpected result word: %s", $realtime, show_result(got));
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("%0t: result mismatch\n  expected %s\n  actual   %s",
                       $realtime, show_result(want), show_result(got));
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we || (in_ch.valid && in_ch.ready) ||
        (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("** stereo_frame_fifo_with_underrun: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // stimulus generation
  int words_made = 0;
  int drain_at = -1;
  int gen_cap = RING_DEPTH;
  int gen_occ = 0;

  function automatic logic [SAMPLE_W-1:0] sample_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_word(int op, int frames, int uf,
                           logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r);
    queued_word_t q;
    q.word = '{op: OP_W'(op), block_frames: BLK_W'(frames), left_in: l, right_in: r,
               host_underflow: (uf != 0)};
    q.wait_drain = (words_made == drain_at);
    pending_words.push_back(q);
    words_made++;
  endtask

  task automatic add_random_words(int n);
    int start, room, len, lim, sent, take;
    start = words_made;
    drain_at = words_made + n / 2;
    while (words_made - start < n) begin
      room = gen_cap - gen_occ;
      lim = $urandom_range(99);
      if (lim < 50) begin
        if (room <= 0 || $urandom_range(9) == 0) begin
          // block too large for the ring or for the free room
          len = $urandom_range(1) ? $urandom_range(room + 1, room + 4)
                                  : $urandom_range(room + 1, MAX_BLOCK);
          push_word(OP_WRITE_BEGIN, len, $urandom_range(1), sample_word(), sample_word());
        end else begin
          lim = (room < 12) ? room : 12;
          if (gen_cap == RING_DEPTH && $urandom_range(15) == 0)
            lim = (room < 300) ? room : 300;
          len = $urandom_range(1, lim);
          sent = ($urandom_range(7) == 0) ? $urandom_range(0, len - 1) : len;
          push_word(OP_WRITE_BEGIN, len, $urandom_range(1), sample_word(), sample_word());
          repeat (sent)
            push_word(OP_WRITE_FRAME, $urandom_range(0, MAX_BLOCK), $urandom_range(1),
                      sample_word(), sample_word());
          if (sent == len) begin
            gen_occ += len;
          end else if ($urandom_range(1)) begin
            // cut-short block closed by an empty one
            push_word(OP_WRITE_BEGIN, 0, $urandom_range(1), sample_word(), sample_word());
          end
        end
      end else if (lim < 85) begin
        len = ($urandom_range(19) == 0) ? $urandom_range(0, MAX_BLOCK)
                                        : $urandom_range(0, gen_occ + 3);
        push_word(OP_READ_BEGIN, len, ($urandom_range(4) == 0), sample_word(), sample_word());
        lim = (len < gen_occ + 4) ? len + 1 : gen_occ + 4;
        sent = $urandom_range(0, lim);
        repeat (sent)
          push_word(OP_READ_FRAME, $urandom_range(0, MAX_BLOCK), $urandom_range(1),
                    sample_word(), sample_word());
        take = (gen_occ < len) ? gen_occ : len;
        if (sent < take) take = sent;
        gen_occ -= take;
      end else begin
        case ($urandom_range(5))
          0: push_word(OP_WRITE_FRAME, $urandom_range(0, MAX_BLOCK), $urandom_range(1),
                       sample_word(), sample_word());
          1: push_word(OP_READ_FRAME, $urandom_range(0, MAX_BLOCK), $urandom_range(1),
                       sample_word(), sample_word());
          2: push_word(OP_CLEAR_UND, $urandom_range(0, MAX_BLOCK), $urandom_range(1),
                       sample_word(), sample_word());
          3: push_word(OP_CLEAR_UND + $urandom_range(1, 3), $urandom_range(0, MAX_BLOCK),
                       $urandom_range(1), sample_word(), sample_word());
          4: push_word(OP_WRITE_BEGIN, 0, $urandom_range(1), sample_word(), sample_word());
          default: push_word(OP_READ_BEGIN, $urandom_range(0, 4), $urandom_range(1),
                             sample_word(), sample_word());
        endcase
      end
      if (gen_occ > gen_cap) gen_occ = gen_cap;
    end
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_ch.valid || due_results.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic change_capacity(int value, int send_pct, int recv_pct);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_data <= CNT_W'(value);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    set_capacity(CNT_W'(value));
    gen_cap = ring_size();
    gen_occ = 0;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = OP_WRITE_BEGIN;
    in_ch.block_frames = '0;
    in_ch.left_in = '0;
    in_ch.right_in = '0;
    in_ch.host_underflow = 1'b0;
    out_ch.ready = 1'b0;
    set_capacity(CNT_W'(RING_DEPTH));
    und_events = '0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // no block open yet
    push_word(OP_READ_FRAME, 0, 1'b0, '0, '0);
    push_word(OP_WRITE_FRAME, 0, 1'b0, '1, '1);
    push_word(OP_READ_BEGIN, 0, 1'b0, '0, '0);
    push_word(OP_READ_BEGIN, 3, 1'b1, '0, '0);
    push_word(OP_READ_FRAME, 0, 1'b0, '0, '0);
    push_word(OP_CLEAR_UND, 0, 1'b0, '0, '0);
    // oversized and empty write blocks
    push_word(OP_WRITE_BEGIN, MAX_BLOCK, 1'b0, '0, '0);
    push_word(OP_WRITE_BEGIN, RING_DEPTH + 1, 1'b0, '0, '0);
    push_word(OP_WRITE_BEGIN, 0, 1'b0, '0, '0);
    push_word(OP_WRITE_FRAME, 0, 1'b0, '1, '1);
    // unfinished block replaced by a new one
    push_word(OP_WRITE_BEGIN, 2, 1'b0, '0, '0);
    push_word(OP_WRITE_FRAME, 0, 1'b0, '1, '1);
    push_word(OP_WRITE_BEGIN, 3, 1'b0, '0, '0);
    push_word(OP_WRITE_FRAME, 0, 1'b0, '0, '0);
    push_word(OP_WRITE_FRAME, 0, 1'b0, '1, '0);
    push_word(OP_WRITE_FRAME, 0, 1'b0, $urandom, $urandom);
    push_word(OP_READ_BEGIN, 2, 1'b1, '0, '0);
    push_word(OP_READ_FRAME, 0, 1'b0, '0, '0);
    push_word(OP_READ_FRAME, 0, 1'b0, '0, '0);
    // short read block then zero fill
    push_word(OP_READ_BEGIN, 5, 1'b0, '0, '0);
    push_word(OP_READ_FRAME, 0, 1'b0, '0, '0);
    push_word(OP_READ_FRAME, 0, 1'b0, '0, '0);
    push_word(OP_READ_BEGIN, 0, 1'b0, '0, '0);
    push_word(OP_READ_FRAME, 0, 1'b0, '0, '0);
    for (int k = 1; k <= 3; k++) push_word(OP_CLEAR_UND + k, 0, 1'b1, '1, '1);
    push_word(OP_READ_BEGIN, MAX_BLOCK, 1'b0, '0, '0);
    push_word(OP_READ_FRAME, 0, 1'b0, '0, '0);

    change_capacity(0, 15, 48);
    add_random_words(90);
    change_capacity(8191, 15, 48);
    add_random_words(110);
    change_capacity(8, 48, 15);
    add_random_words(120);
    change_capacity($urandom_range(2, 64), 48, 15);
    add_random_words(120);
    change_capacity(RING_DEPTH, 0, 0);
    add_random_words(110);
    change_capacity(5, 0, 0);
    add_random_words(90);

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && due_results.size() == 0) begin
      $display("** stereo_frame_fifo_with_underrun: PASSED **");
    end else begin
      $display("** stereo_frame_fifo_with_underrun: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/sff_pkg.sv
sv/sff_in_if.sv
sv/sff_out_if.sv
sv/sff_ram.sv
sv/sff_ctrl.sv
sv/sff_dp.sv
sv/stereo_frame_fifo_with_underrun.sv
test/tb.sv
